// File: rtl/lscd_pkg.sv
// ----------------------------------------------------------------------------
// lscd_pkg: shared definitions for the limited stock change dispenser
// Denomination table, stock reset values, division constants and the
// record that travels down the dispenser pipeline.
// ----------------------------------------------------------------------------
package lscd_pkg;

    localparam int NUM_DENOMS = 7;
    localparam int NUM_STAGES = NUM_DENOMS + 1;

    localparam int STOCK_MAX = 255;
    localparam logic [7:0] STOCK_LIMIT = (STOCK_MAX > 255) ? 8'd255 : 8'(STOCK_MAX);

    localparam logic KIND_RESTOCK = 1'b0;
    localparam logic KIND_CHANGE  = 1'b1;

    localparam logic [2:0] DENOM_200  = 3'd0;
    localparam logic [2:0] DENOM_100  = 3'd1;
    localparam logic [2:0] DENOM_50   = 3'd2;
    localparam logic [2:0] DENOM_10   = 3'd3;
    localparam logic [2:0] DENOM_5    = 3'd4;
    localparam logic [2:0] DENOM_ONE  = 3'd5;
    localparam logic [2:0] DENOM_HALF = 3'd6;

    // Values in half units, largest first.
    localparam logic [8:0] DENOM_VALUE [NUM_DENOMS] =
        '{9'd400, 9'd200, 9'd100, 9'd20, 9'd10, 9'd2, 9'd1};

    localparam logic [7:0] STOCK_RESET [NUM_DENOMS] =
        '{8'd2, 8'd4, 8'd6, 8'd10, 8'd10, 8'd20, 8'd20};

    // Reciprocal constants, exact for the operand ranges used below.
    localparam logic [14:0] DIV25_MUL   = 15'd20972;
    localparam int          DIV25_SHIFT = 19;
    localparam logic [14:0] DIV5_MUL    = 15'd26215;
    localparam int          DIV5_SHIFT  = 17;

    typedef struct packed {
        logic                 kind;
        logic [2:0]           denom_index;
        logic [7:0]           stock_count;
        logic [15:0]          rem;
        logic [6:0][7:0]      take;
    } stage_t;

    function automatic logic [7:0] clamp_stock(input logic [7:0] value);
        return (value > STOCK_LIMIT) ? STOCK_LIMIT : value;
    endfunction

    // Quotient of a half-unit amount by one denomination value.
    function automatic logic [15:0] denom_quot(input logic [2:0] sel,
                                               input logic [15:0] rem);
        logic [31:0] prod;
        logic [15:0] quot;
        prod = '0;
        quot = '0;
        case (sel)
            DENOM_200:
            begin
                prod = 32'(rem[15:4]) * 32'(DIV25_MUL);
                quot = 16'(prod >> DIV25_SHIFT);
            end
            DENOM_100:
            begin
                prod = 32'(rem[15:3]) * 32'(DIV25_MUL);
                quot = 16'(prod >> DIV25_SHIFT);
            end
            DENOM_50:
            begin
                prod = 32'(rem[15:2]) * 32'(DIV25_MUL);
                quot = 16'(prod >> DIV25_SHIFT);
            end
            DENOM_10:
            begin
                prod = 32'(rem[15:2]) * 32'(DIV5_MUL);
                quot = 16'(prod >> DIV5_SHIFT);
            end
            DENOM_5:
            begin
                prod = 32'(rem[15:1]) * 32'(DIV5_MUL);
                quot = 16'(prod >> DIV5_SHIFT);
            end
            DENOM_ONE:
            begin
                quot = {1'b0, rem[15:1]};
            end
            DENOM_HALF:
            begin
                quot = rem;
            end
            default:
            begin
                quot = '0;
            end
        endcase
        return quot;
    endfunction

endpackage

// File: rtl/limited_stock_change_dispenser.sv
// ----------------------------------------------------------------------------
// limited_stock_change_dispenser: greedy change payout from limited stock
// Holds a piece count for seven denominations. A restock request sets one
// count; a change request pays its amount largest denomination first.
//
//   Channel   Handshake              Payload
//   request   req_valid / req_stall  kind, denom_index, stock_count, amount
//   result    res_valid / res_stall  notes_*, coins_*, unpaid_amount,
//                                    short_flag
//
// A request is registered, then passes seven stages, one per denomination,
// each of which owns that denomination's stock count.
// One request is taken every cycle unless req_stall is high.
// Reset loads the stock counts 2, 4, 6, 10, 10, 20, 20, largest first.
// A stalled result holds each stage that is full; empty stages keep filling.
// ----------------------------------------------------------------------------
module limited_stock_change_dispenser
    import lscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic        kind,
    input  logic [2:0]  denom_index,
    input  logic [7:0]  stock_count,
    input  logic [15:0] amount,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  notes_200,
    output logic [7:0]  notes_100,
    output logic [7:0]  notes_50,
    output logic [7:0]  notes_10,
    output logic [7:0]  notes_5,
    output logic [7:0]  coins_one,
    output logic [7:0]  coins_half,
    output logic [15:0] unpaid_amount,
    output logic        short_flag
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] space;
    logic [NUM_STAGES-1:0] move;

    stage_t pipe_reg  [NUM_STAGES];
    stage_t pipe_next [NUM_STAGES];
    stage_t stage_out [NUM_DENOMS];

    logic [7:0] stock_reg  [NUM_DENOMS];
    logic [7:0] stock_next [NUM_DENOMS];

    always_comb
    begin
        space[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !res_stall;
        move[NUM_STAGES-1]  = valid_reg[NUM_STAGES-1] && !res_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            move[i]  = valid_reg[i] && space[i+1];
            space[i] = !valid_reg[i] || move[i];
        end
    end

    assign req_stall = !space[0];

    always_comb
    begin
        logic [15:0] quot;
        logic [7:0]  take;
        logic [16:0] paid;
        for (int i = 0; i < NUM_DENOMS; i++)
        begin
            stage_out[i] = pipe_reg[i];
            stock_next[i] = stock_reg[i];
            quot = denom_quot(3'(i), pipe_reg[i].rem);
            take = (quot > {8'd0, stock_reg[i]}) ? stock_reg[i] : quot[7:0];
            paid = {9'd0, take} * {8'd0, DENOM_VALUE[i]};
            if (pipe_reg[i].kind == KIND_CHANGE)
            begin
                stage_out[i].take[i] = take;
                stage_out[i].rem     = pipe_reg[i].rem - paid[15:0];
            end
            if (move[i])
            begin
                if (pipe_reg[i].kind == KIND_CHANGE)
                begin
                    stock_next[i] = stock_reg[i] - take;
                end
                else if (pipe_reg[i].denom_index == 3'(i))
                begin
                    stock_next[i] = clamp_stock(pipe_reg[i].stock_count);
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            pipe_next[i] = pipe_reg[i];
        end
        if (space[0])
        begin
            valid_next[0] = req_valid;
            if (req_valid)
            begin
                pipe_next[0].kind        = kind;
                pipe_next[0].denom_index = denom_index;
                pipe_next[0].stock_count = stock_count;
                pipe_next[0].rem         = (kind == KIND_CHANGE) ? amount : 16'd0;
                pipe_next[0].take        = '0;
            end
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (space[i])
            begin
                valid_next[i] = move[i-1];
                if (move[i-1])
                begin
                    pipe_next[i] = stage_out[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_DENOMS; i++)
            begin
                stock_reg[i] <= clamp_stock(STOCK_RESET[i]);
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < NUM_DENOMS; i++)
            begin
                stock_reg[i] <= stock_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            pipe_reg[i] <= pipe_next[i];
        end
    end

    assign res_valid     = valid_reg[NUM_STAGES-1];
    assign notes_200     = pipe_reg[NUM_STAGES-1].take[DENOM_200];
    assign notes_100     = pipe_reg[NUM_STAGES-1].take[DENOM_100];
    assign notes_50      = pipe_reg[NUM_STAGES-1].take[DENOM_50];
    assign notes_10      = pipe_reg[NUM_STAGES-1].take[DENOM_10];
    assign notes_5       = pipe_reg[NUM_STAGES-1].take[DENOM_5];
    assign coins_one     = pipe_reg[NUM_STAGES-1].take[DENOM_ONE];
    assign coins_half    = pipe_reg[NUM_STAGES-1].take[DENOM_HALF];
    assign unpaid_amount = pipe_reg[NUM_STAGES-1].rem;
    assign short_flag    = |pipe_reg[NUM_STAGES-1].rem;

    // The request side only stalls when every stage is full and the result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (&valid_reg) && res_stall)
        else $error("request stalled while the pipeline has room");

    // A restock result carries no payout and no remainder.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (pipe_reg[NUM_STAGES-1].kind == KIND_RESTOCK)
        |-> (pipe_reg[NUM_STAGES-1].take == '0) && (unpaid_amount == 16'd0))
        else $error("restock result is not all zero");

    // A remainder left after the half-unit stage means that stock ran dry.
    assert property (@(posedge clk) disable iff (!rst_n)
        move[DENOM_HALF] && (pipe_reg[DENOM_HALF].kind == KIND_CHANGE)
        && (stage_out[DENOM_HALF].rem != 16'd0)
        |=> stock_reg[DENOM_HALF] == 8'd0)
        else $error("short result while half-unit stock remains");

endmodule

// File: bench/payout_checker.sv
// ----------------------------------------------------------------------------
// payout_checker: scoreboard for the limited stock change dispenser
// Watches the request and result channels. Each accepted request updates a
// private copy of the denomination stock and yields the expected payout,
// which is compared field by field with the next accepted result.
// ----------------------------------------------------------------------------
module payout_checker
    import lscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    input  logic        req_stall,
    input  logic        kind,
    input  logic [2:0]  denom_index,
    input  logic [7:0]  stock_count,
    input  logic [15:0] amount,

    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [7:0]  notes_200,
    input  logic [7:0]  notes_100,
    input  logic [7:0]  notes_50,
    input  logic [7:0]  notes_10,
    input  logic [7:0]  notes_5,
    input  logic [7:0]  coins_one,
    input  logic [7:0]  coins_half,
    input  logic [15:0] unpaid_amount,
    input  logic        short_flag,

    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [6:0][7:0] pieces;
        logic [15:0]     unpaid;
        logic            short_pay;
    } payout_t;

    logic [7:0] stock_left [NUM_DENOMS];
    payout_t    expected_payouts [$];
    payout_t    want;
    payout_t    got;
    string      piece_names [NUM_DENOMS] = '{"notes_200", "notes_100", "notes_50",
        "notes_10", "notes_5", "coins_one", "coins_half"};

    function automatic int unsigned half_units(input logic [2:0] sel);
        case (sel)
            DENOM_200:  return 400;
            DENOM_100:  return 200;
            DENOM_50:   return 100;
            DENOM_10:   return 20;
            DENOM_5:    return 10;
            DENOM_ONE:  return 2;
            default:    return 1;
        endcase
    endfunction

    function automatic payout_t predict_payout(input logic req_kind,
                                               input logic [2:0] idx,
                                               input logic [7:0] cnt,
                                               input logic [15:0] amt);
        payout_t     p;
        int unsigned remaining;
        int unsigned take;
        int          i;
        p = '0;
        if (req_kind == KIND_RESTOCK)
        begin
            if (idx < NUM_DENOMS)
                stock_left[idx] = (cnt > STOCK_LIMIT) ? STOCK_LIMIT : cnt;
        end
        else
        begin
            remaining = amt;
            for (i = 0; i < NUM_DENOMS; i++)
            begin
                take = remaining / half_units(3'(i));
                if (take > stock_left[i])
                    take = stock_left[i];
                stock_left[i] = stock_left[i] - 8'(take);
                remaining = remaining - take * half_units(3'(i));
                p.pieces[i] = 8'(take);
            end
            p.unpaid = 16'(remaining);
            p.short_pay = (remaining != 0);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string field, input int want_val, input int got_val);
        $display("%0t: mismatch on %s, expected %0d, actual %0d",
                 $time, field, want_val, got_val);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stock_left[0] = 8'd2;
            stock_left[1] = 8'd4;
            stock_left[2] = 8'd6;
            stock_left[3] = 8'd10;
            stock_left[4] = 8'd10;
            stock_left[5] = 8'd20;
            stock_left[6] = 8'd20;
            expected_payouts.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_payouts.push_back(predict_payout(kind, denom_index,
                                                          stock_count, amount));
            if (res_valid && !res_stall)
            begin
                got.pieces = {coins_half, coins_one, notes_5, notes_10,
                              notes_50, notes_100, notes_200};
                got.unpaid = unpaid_amount;
                got.short_pay = short_flag;
                if (expected_payouts.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, actual unpaid %0d",
                             $time, unpaid_amount);
                    fail_count++;
                end
                else
                begin
                    want = expected_payouts.pop_front();
                    for (int i = 0; i < NUM_DENOMS; i++)
                        if (got.pieces[i] !== want.pieces[i])
                            report_mismatch(piece_names[i], want.pieces[i], got.pieces[i]);
                    if (got.unpaid !== want.unpaid)
                        report_mismatch("unpaid_amount", want.unpaid, got.unpaid);
                    if (got.short_pay !== want.short_pay)
                        report_mismatch("short_flag", want.short_pay, got.short_pay);
                end
            end
            pending = expected_payouts.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the limited stock change dispenser
// Drives directed and then random restock and change requests in bursts
// while the result side stalls on its own pattern. A checker beside the
// block predicts every payout; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import lscd_pkg::*;
();

    localparam int RANDOM_REQUESTS = 1600;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        kind = KIND_RESTOCK;
    logic [2:0]  denom_index = DENOM_200;
    logic [7:0]  stock_count = 8'd0;
    logic [15:0] amount = 16'd0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  notes_200;
    logic [7:0]  notes_100;
    logic [7:0]  notes_50;
    logic [7:0]  notes_10;
    logic [7:0]  notes_5;
    logic [7:0]  coins_one;
    logic [7:0]  coins_half;
    logic [15:0] unpaid_amount;
    logic        short_flag;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    int          stall_mode = 0;
    int          stall_mode_left = 0;

    always #10 clk = ~clk;

    limited_stock_change_dispenser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .denom_index  (denom_index),
        .stock_count  (stock_count),
        .amount       (amount),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .notes_200    (notes_200),
        .notes_100    (notes_100),
        .notes_50     (notes_50),
        .notes_10     (notes_10),
        .notes_5      (notes_5),
        .coins_one    (coins_one),
        .coins_half   (coins_half),
        .unpaid_amount(unpaid_amount),
        .short_flag   (short_flag)
    );

    payout_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .denom_index  (denom_index),
        .stock_count  (stock_count),
        .amount       (amount),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .notes_200    (notes_200),
        .notes_100    (notes_100),
        .notes_50     (notes_50),
        .notes_10     (notes_10),
        .notes_5      (notes_5),
        .coins_one    (coins_one),
        .coins_half   (coins_half),
        .unpaid_amount(unpaid_amount),
        .short_flag   (short_flag),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // The result side switches between free flow, light random stalls and
    // long stretches of mostly stalled cycles.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_mode_left = $urandom_range(20, 80);
            end
            else
            begin
                stall_mode_left = stall_mode_left - 1;
            end
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 2) == 0);
                default: res_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(input logic req_kind, input logic [2:0] idx,
                                input logic [7:0] cnt, input logic [15:0] amt);
        req_valid <= 1'b1;
        kind <= req_kind;
        denom_index <= idx;
        stock_count <= cnt;
        amount <= amt;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain_payouts();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_restock(input logic [2:0] idx, input logic [7:0] cnt);
        send_request(KIND_RESTOCK, idx, cnt, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_change(input logic [15:0] amt);
        send_request(KIND_CHANGE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), amt);
    endtask

    task automatic send_random_request();
        logic [2:0]  idx;
        logic [7:0]  cnt;
        logic [15:0] amt;
        if ($urandom_range(0, 99) < 22)
        begin
            idx = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            case ($urandom_range(0, 5))
                0:       cnt = 8'd0;
                1:       cnt = 8'd255;
                2, 3:    cnt = 8'($urandom_range(0, 30));
                default: cnt = 8'($urandom_range(0, 255));
            endcase
            send_restock(idx, cnt);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       amt = 16'd0;
                1, 2:    amt = 16'($urandom_range(1, 60));
                3, 4:    amt = 16'($urandom_range(0, 600));
                5, 6:    amt = 16'($urandom_range(0, 4000));
                7:       amt = 16'($urandom_range(0, 3) * 400 + $urandom_range(0, 2) * 100
                                   + $urandom_range(0, 4) * 20 + $urandom_range(0, 1));
                default: amt = 16'($urandom_range(0, 65535));
            endcase
            send_change(amt);
        end
    endtask

    initial
    begin
        int sent;
        int burst_len;
        int since_drain;
        bit no_gaps;

        sent = 0;
        since_drain = 0;
        no_gaps = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_change(16'd0);
        send_change(16'd1);
        send_change(16'd3);
        send_change(16'd1234);
        send_change(16'd65535);
        send_change(16'd5);
        send_restock(DENOM_200, 8'd255);
        send_restock(DENOM_100, 8'd255);
        send_restock(DENOM_50, 8'd255);
        send_restock(DENOM_10, 8'd255);
        send_restock(DENOM_5, 8'd255);
        send_restock(DENOM_ONE, 8'd255);
        send_restock(DENOM_HALF, 8'd255);
        send_request(KIND_RESTOCK, 3'd7, 8'd99, 16'hFFFF);
        send_change(16'd65535);
        send_restock(DENOM_200, 8'd0);
        send_change(16'd400);
        send_change(16'h5555);
        send_restock(DENOM_HALF, 8'd0);
        send_change(16'd21);
        send_restock(DENOM_ONE, 8'd128);
        send_change(16'hAAAA);
        send_change(16'd65535);
        drain_payouts();

        while (sent < RANDOM_REQUESTS)
        begin
            if (sent % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            burst_len = $urandom_range(1, 16);
            for (int i = 0; i < burst_len; i++)
            begin
                send_random_request();
                sent++;
                since_drain++;
            end
            if (since_drain >= 400)
            begin
                drain_payouts();
                since_drain = 0;
            end
            else if (!no_gaps && $urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 8));
            end
        end

        drain_payouts();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
